@@ sv/epoch_seconds_to_local_calendar_top_assert.svh @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_local_calendar_top_assert.svh
// assertion macros shared by the calendar converter
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_LOCAL_CALENDAR_TOP_ASSERT_SVH
`define EPOCH_SECONDS_TO_LOCAL_CALENDAR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define ESTLC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("estlc: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define ESTLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("estlc: next-cycle check failed");

`endif

@@ sv/estlc_pkg.sv @@
// ----------------------------------------------------------------------------
// estlc_pkg
// types, constants and calendar helpers for the epoch to calendar converter
// ----------------------------------------------------------------------------
package estlc_pkg;

    // time constants
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    // local count starts on 1969-01-01, one common year before the epoch
    localparam int unsigned SECS_BASE_YEAR = 365 * SECS_PER_DAY;

    // calendar constants, years counted from 1900
    localparam int unsigned BASE_YEAR_OFS   = 69;
    localparam int unsigned GAP_YEAR_OFS    = 200;
    localparam int unsigned SHORT_BLOCK_OFS = GAP_YEAR_OFS - 3;
    localparam int unsigned BLOCK_DAYS      = 365 + 365 + 365 + 366;
    localparam int unsigned LAST_MONTH_IDX  = 11;

    // widths
    localparam int ACC_W   = 33;
    localparam int DAYS_W  = 16;
    localparam int STEP_W  = 4;
    localparam int ZONE_W  = 5;
    localparam int ZSEC_W  = 18;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // quotient bit counts of the three divisions
    localparam int DAY_QBITS  = 16;
    localparam int HOUR_QBITS = 5;
    localparam int MIN_QBITS  = 6;

    // register map
    localparam logic REG_ZONE_OFFSET = 1'b0;
    localparam logic signed [ZONE_W-1:0] ZONE_RESET = 5'sd8;

    // operations of the shared compare-subtract unit
    typedef enum logic [2:0] {
        OP_DAY   = 3'd0,
        OP_HOUR  = 3'd1,
        OP_MIN   = 3'd2,
        OP_BLOCK = 3'd3,
        OP_YEAR  = 3'd4,
        OP_MONTH = 3'd5
    } op_t;

    // sequencer states
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DAYS   = 8'b0000_0010,
        ST_HOURS  = 8'b0000_0100,
        ST_MINS   = 8'b0000_1000,
        ST_BLOCK  = 8'b0001_0000,
        ST_YEAR   = 8'b0010_0000,
        ST_MONTH  = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic              ge;
        logic [ACC_W-1:0]  diff;
    } sub_res_t;

    typedef struct packed {
        state_t      state;
        logic [3:0]  month_idx;
    } eng_stat_t;

    // gregorian leap test over 1969..2106, year given as offset from 1900
    function automatic logic is_leap(input logic [7:0] yoff);
        is_leap = (yoff[1:0] == 2'b00) && (yoff != 8'(GAP_YEAR_OFS));
    endfunction

    // days in a month, month index from 0
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        case (m)
            4'd0:    month_len = 5'd31;
            4'd1:    month_len = leap ? 5'd29 : 5'd28;
            4'd2:    month_len = 5'd31;
            4'd3:    month_len = 5'd30;
            4'd4:    month_len = 5'd31;
            4'd5:    month_len = 5'd30;
            4'd6:    month_len = 5'd31;
            4'd7:    month_len = 5'd31;
            4'd8:    month_len = 5'd30;
            4'd9:    month_len = 5'd31;
            4'd10:   month_len = 5'd30;
            4'd11:   month_len = 5'd31;
            default: month_len = 5'd31;
        endcase
    endfunction

endpackage

@@ sv/epoch_seconds_to_local_calendar_top.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_local_calendar_top
// converts a 32-bit unix seconds count to local calendar date and time
// ----------------------------------------------------------------------------
// usage
//   request in: epoch_seconds with in_valid; taken when in_valid is high and
//   in_stall is low. in_stall stays high while a request is being converted.
//   result out: six calendar fields with out_valid; taken when out_stall is low.
//   zone_offset_hours sits at byte address 0 of the register port; it is added
//   to the seconds before the conversion, so day, month and year carry.
// sequence
//   one request at a time. a request runs the day division, then the hour and
//   minute divisions, then one step per four-year block, per single year and
//   per month, all on the one shared compare-subtract unit.
// reset and stall
//   reset empties the block and sets the zone offset to +8 hours. a stalled
//   result holds in the output register; the next request is accepted and
//   converted meanwhile and waits until the output register is free.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_local_calendar_top_assert.svh"

module epoch_seconds_to_local_calendar_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [estlc_pkg::ADDR_W-1:0]      paddr,
    input  logic [estlc_pkg::DATA_W-1:0]      pwdata,
    output logic [estlc_pkg::DATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [31:0]                       epoch_seconds,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        year_since_1900,
    output logic [3:0]                        month_number,
    output logic [4:0]                        day_of_month,
    output logic [4:0]                        hour_of_day,
    output logic [5:0]                        minute_of_hour,
    output logic [5:0]                        second_of_minute
);

    logic signed [estlc_pkg::ZSEC_W-1:0] zone_secs;
    estlc_pkg::eng_stat_t                stat;

    // configuration registers
    estlc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .zone_secs (zone_secs)
    );

    // conversion sequencer
    estlc_engine u_engine
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .epoch_seconds    (epoch_seconds),
        .zone_secs        (zone_secs),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .year_since_1900  (year_since_1900),
        .month_number     (month_number),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .stat             (stat)
    );

    // an accepted request starts the day division
    `ESTLC_ASSERT_NEXT(a_start_days, in_valid && !in_stall, stat.state == estlc_pkg::ST_DAYS)

    // month walk never passes december
    `ESTLC_ASSERT_NOW(a_month_bound, stat.state == estlc_pkg::ST_MONTH, stat.month_idx <= 4'd11)

    // a presented result is a well-formed date and time
    `ESTLC_ASSERT_NOW(a_result_range, out_valid, (month_number >= 4'd1) && (month_number <= 4'd12) && (day_of_month >= 5'd1) && (hour_of_day <= 5'd23) && (minute_of_hour <= 6'd59) && (second_of_minute <= 6'd59) && (year_since_1900 >= 8'd69) && (year_since_1900 <= 8'd206))

endmodule

@@ sv/estlc_cfg.sv @@
// ----------------------------------------------------------------------------
// estlc_cfg
// register port holding the zone offset and its value in seconds
// ----------------------------------------------------------------------------
module estlc_cfg
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [estlc_pkg::ADDR_W-1:0]             paddr,
    input  logic [estlc_pkg::DATA_W-1:0]             pwdata,
    output logic [estlc_pkg::DATA_W-1:0]             prdata,
    output logic                                     pready,
    output logic signed [estlc_pkg::ZSEC_W-1:0]      zone_secs
);

    logic signed [estlc_pkg::ZONE_W-1:0] zone_reg;
    logic                                wr_en;
    logic                                sel_zone;

    assign pready   = 1'b1;
    assign sel_zone = (paddr[2] == estlc_pkg::REG_ZONE_OFFSET);
    assign wr_en    = psel && penable && pwrite && pready && sel_zone;

    // zone offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= estlc_pkg::ZONE_RESET;
        end
        else if (wr_en)
        begin
            zone_reg <= $signed(pwdata[estlc_pkg::ZONE_W-1:0]);
        end
    end

    // read back, sign extended
    always_comb
    begin
        if (sel_zone)
        begin
            prdata = {{(estlc_pkg::DATA_W-estlc_pkg::ZONE_W){zone_reg[estlc_pkg::ZONE_W-1]}},
                      zone_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // offset in seconds, small constant multiply
    assign zone_secs = estlc_pkg::ZSEC_W'(zone_reg * 18'sd3600);

endmodule

@@ sv/estlc_sub_unit.sv @@
// ----------------------------------------------------------------------------
// estlc_sub_unit
// shared compare-subtract unit with its divisor and length selection
// ----------------------------------------------------------------------------
module estlc_sub_unit
(
    input  logic [estlc_pkg::ACC_W-1:0]   a,
    input  estlc_pkg::op_t                op,
    input  logic [estlc_pkg::STEP_W-1:0]  step,
    input  logic [7:0]                    yoff,
    input  logic [3:0]                    month_idx,
    output estlc_pkg::sub_res_t           res
);

    logic [estlc_pkg::ACC_W-1:0] b;
    logic                        leap;

    assign leap = estlc_pkg::is_leap(yoff);

    // subtrahend for each operation
    always_comb
    begin
        case (op)
            estlc_pkg::OP_DAY:
                b = estlc_pkg::ACC_W'(estlc_pkg::SECS_PER_DAY) << step;
            estlc_pkg::OP_HOUR:
                b = estlc_pkg::ACC_W'(estlc_pkg::SECS_PER_HOUR) << step;
            estlc_pkg::OP_MIN:
                b = estlc_pkg::ACC_W'(estlc_pkg::SECS_PER_MIN) << step;
            estlc_pkg::OP_BLOCK:
                b = (yoff == 8'(estlc_pkg::SHORT_BLOCK_OFS))
                    ? estlc_pkg::ACC_W'(estlc_pkg::BLOCK_DAYS - 1)
                    : estlc_pkg::ACC_W'(estlc_pkg::BLOCK_DAYS);
            estlc_pkg::OP_YEAR:
                b = leap ? estlc_pkg::ACC_W'(366) : estlc_pkg::ACC_W'(365);
            estlc_pkg::OP_MONTH:
                b = estlc_pkg::ACC_W'(estlc_pkg::month_len(leap, month_idx));
            default:
                b = '0;
        endcase
    end

    // compare and subtract
    assign res.ge   = (a >= b);
    assign res.diff = a - b;

endmodule

@@ sv/estlc_engine.sv @@
// ----------------------------------------------------------------------------
// estlc_engine
// sequencer, working registers and result register of the converter
// ----------------------------------------------------------------------------
module estlc_engine
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [31:0]                          epoch_seconds,
    input  logic signed [estlc_pkg::ZSEC_W-1:0]  zone_secs,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [7:0]                           year_since_1900,
    output logic [3:0]                           month_number,
    output logic [4:0]                           day_of_month,
    output logic [4:0]                           hour_of_day,
    output logic [5:0]                           minute_of_hour,
    output logic [5:0]                           second_of_minute,
    output estlc_pkg::eng_stat_t                 stat
);

    localparam int ACC_W  = estlc_pkg::ACC_W;
    localparam int DAYS_W = estlc_pkg::DAYS_W;
    localparam int STEP_W = estlc_pkg::STEP_W;

    estlc_pkg::state_t     state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;

    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [DAYS_W-1:0]     quo_reg, quo_next;
    logic [DAYS_W-1:0]     days_reg, days_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [4:0]            hour_reg, hour_next;
    logic [5:0]            minute_reg, minute_next;
    logic [7:0]            yoff_reg, yoff_next;
    logic [3:0]            month_reg, month_next;

    logic [7:0]            o_year_reg, o_year_next;
    logic [3:0]            o_month_reg, o_month_next;
    logic [4:0]            o_day_reg, o_day_next;
    logic [4:0]            o_hour_reg, o_hour_next;
    logic [5:0]            o_min_reg, o_min_next;
    logic [5:0]            o_sec_reg, o_sec_next;

    estlc_pkg::op_t        op;
    logic [ACC_W-1:0]      unit_a;
    estlc_pkg::sub_res_t   res;
    logic [ACC_W-1:0]      local_secs;
    logic [DAYS_W-1:0]     quo_shift;
    logic                  last_step;

    // local seconds from 1969-01-01
    assign local_secs = ACC_W'({1'b0, epoch_seconds})
                      + ACC_W'(estlc_pkg::SECS_BASE_YEAR)
                      + {{(ACC_W-estlc_pkg::ZSEC_W){zone_secs[estlc_pkg::ZSEC_W-1]}},
                         zone_secs};

    assign quo_shift = {quo_reg[DAYS_W-2:0], res.ge};
    assign last_step = (step_reg == '0);

    // operation and operand for the shared unit
    always_comb
    begin
        case (state_reg)
            estlc_pkg::ST_DAYS:  op = estlc_pkg::OP_DAY;
            estlc_pkg::ST_HOURS: op = estlc_pkg::OP_HOUR;
            estlc_pkg::ST_MINS:  op = estlc_pkg::OP_MIN;
            estlc_pkg::ST_BLOCK: op = estlc_pkg::OP_BLOCK;
            estlc_pkg::ST_YEAR:  op = estlc_pkg::OP_YEAR;
            estlc_pkg::ST_MONTH: op = estlc_pkg::OP_MONTH;
            default:             op = estlc_pkg::OP_DAY;
        endcase
    end

    assign unit_a = (state_reg == estlc_pkg::ST_DAYS || state_reg == estlc_pkg::ST_HOURS ||
                     state_reg == estlc_pkg::ST_MINS)
                    ? acc_reg : ACC_W'(days_reg);

    estlc_sub_unit u_sub
    (
        .a         (unit_a),
        .op        (op),
        .step      (step_reg),
        .yoff      (yoff_reg),
        .month_idx (month_reg),
        .res       (res)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        acc_next       = acc_reg;
        quo_next       = quo_reg;
        days_next      = days_reg;
        step_next      = step_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        yoff_next      = yoff_reg;
        month_next     = month_reg;
        o_year_next    = o_year_reg;
        o_month_next   = o_month_reg;
        o_day_next     = o_day_reg;
        o_hour_next    = o_hour_reg;
        o_min_next     = o_min_reg;
        o_sec_next     = o_sec_reg;

        // result taken by the receiver
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            estlc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    acc_next   = local_secs;
                    quo_next   = '0;
                    step_next  = STEP_W'(estlc_pkg::DAY_QBITS - 1);
                    state_next = estlc_pkg::ST_DAYS;
                end
            end
            // restoring division by seconds per day
            estlc_pkg::ST_DAYS:
            begin
                if (res.ge)
                begin
                    acc_next = res.diff;
                end
                quo_next = quo_shift;
                if (last_step)
                begin
                    days_next  = quo_shift;
                    quo_next   = '0;
                    step_next  = STEP_W'(estlc_pkg::HOUR_QBITS - 1);
                    state_next = estlc_pkg::ST_HOURS;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            // hours out of the second of day
            estlc_pkg::ST_HOURS:
            begin
                if (res.ge)
                begin
                    acc_next = res.diff;
                end
                quo_next = quo_shift;
                if (last_step)
                begin
                    hour_next  = quo_shift[4:0];
                    quo_next   = '0;
                    step_next  = STEP_W'(estlc_pkg::MIN_QBITS - 1);
                    state_next = estlc_pkg::ST_MINS;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            // minutes, the remainder is the second
            estlc_pkg::ST_MINS:
            begin
                if (res.ge)
                begin
                    acc_next = res.diff;
                end
                quo_next = quo_shift;
                if (last_step)
                begin
                    minute_next = quo_shift[5:0];
                    yoff_next   = 8'(estlc_pkg::BASE_YEAR_OFS);
                    state_next  = estlc_pkg::ST_BLOCK;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            // skip whole four-year blocks
            estlc_pkg::ST_BLOCK:
            begin
                if (res.ge)
                begin
                    days_next = res.diff[DAYS_W-1:0];
                    yoff_next = yoff_reg + 8'd4;
                end
                else
                begin
                    state_next = estlc_pkg::ST_YEAR;
                end
            end
            // single years
            estlc_pkg::ST_YEAR:
            begin
                if (res.ge)
                begin
                    days_next = res.diff[DAYS_W-1:0];
                    yoff_next = yoff_reg + 8'd1;
                end
                else
                begin
                    month_next = '0;
                    state_next = estlc_pkg::ST_MONTH;
                end
            end
            // months of the year
            estlc_pkg::ST_MONTH:
            begin
                if (res.ge && (month_reg != 4'(estlc_pkg::LAST_MONTH_IDX)))
                begin
                    days_next  = res.diff[DAYS_W-1:0];
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    state_next = estlc_pkg::ST_FINISH;
                end
            end
            // hand over to the result register once it is free
            estlc_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    o_year_next    = yoff_reg;
                    o_month_next   = month_reg + 4'd1;
                    o_day_next     = days_reg[4:0] + 5'd1;
                    o_hour_next    = hour_reg;
                    o_min_next     = minute_reg;
                    o_sec_next     = acc_reg[5:0];
                    out_valid_next = 1'b1;
                    state_next     = estlc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = estlc_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= estlc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        quo_reg     <= quo_next;
        days_reg    <= days_next;
        step_reg    <= step_next;
        hour_reg    <= hour_next;
        minute_reg  <= minute_next;
        yoff_reg    <= yoff_next;
        month_reg   <= month_next;
        o_year_reg  <= o_year_next;
        o_month_reg <= o_month_next;
        o_day_reg   <= o_day_next;
        o_hour_reg  <= o_hour_next;
        o_min_reg   <= o_min_next;
        o_sec_reg   <= o_sec_next;
    end

    assign in_stall         = (state_reg != estlc_pkg::ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign year_since_1900  = o_year_reg;
    assign month_number     = o_month_reg;
    assign day_of_month     = o_day_reg;
    assign hour_of_day      = o_hour_reg;
    assign minute_of_hour   = o_min_reg;
    assign second_of_minute = o_sec_reg;

    assign stat.state     = state_reg;
    assign stat.month_idx = month_reg;

endmodule
